// ===== rtl/window_mean_variance_band_detector_macros.svh =====
// Assertion macros used by the detector's top-level RTL file.
`ifndef WINDOW_MEAN_VARIANCE_BAND_DETECTOR_MACROS_SVH
`define WINDOW_MEAN_VARIANCE_BAND_DETECTOR_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define WMVBD_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error("%m failed");

// When the condition holds, the consequence must hold at the next clock.
`define WMVBD_ASSERT_NEXT(lbl, ck, rst_n, cond, conseq) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error("%m failed");

`endif

// ===== rtl/wmvbd_pkg.sv =====
// Types, sizes and register codes of the window mean/variance band detector.
package wmvbd_pkg;

	localparam int WINDOW = 10;
	localparam int SAMP_W = 7;
	localparam int BRIGHT_MAX = 100;
	localparam int SQ_MAX = BRIGHT_MAX * BRIGHT_MAX;

	localparam int SUM_W = $clog2(BRIGHT_MAX * WINDOW + 1);
	localparam int SQ_W = $clog2(SQ_MAX * WINDOW + 1);
	localparam int SPREAD_W = $clog2(SQ_MAX * WINDOW * WINDOW + 1);
	localparam int LIM_W = $clog2(4095 * WINDOW * WINDOW + 1);
	localparam int CMP_W = (SPREAD_W > LIM_W) ? SPREAD_W : LIM_W;
	localparam int FLOOR_W = $clog2(127 * WINDOW + 1);
	localparam int MEAN_W = (SUM_W > FLOOR_W) ? SUM_W : FLOOR_W;

	localparam int FLOOR_CFG_W = 7;
	localparam int VAR_CFG_W = 12;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam int TDATA_W = 8;

	localparam logic [FLOOR_CFG_W-1:0] MEAN_FLOOR_RST = 7'd50;
	localparam logic [VAR_CFG_W-1:0] VAR_LOW_RST = 12'd200;
	localparam logic [VAR_CFG_W-1:0] VAR_HIGH_RST = 12'd700;
	localparam logic [FLOOR_CFG_W-1:0] CEILING_RST = 7'd50;

	typedef enum logic [1:0] {
		REG_MEAN_FLOOR = 2'd0,
		REG_VAR_LOW = 2'd1,
		REG_VAR_HIGH = 2'd2,
		REG_NEWEST_CEILING = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [FLOOR_CFG_W-1:0] mean_floor;
		logic [VAR_CFG_W-1:0] variance_low;
		logic [VAR_CFG_W-1:0] variance_high;
		logic [FLOOR_CFG_W-1:0] newest_ceiling;
	} cfg_t;

	// Window statistics right after an item has been shifted in.
	typedef struct packed {
		logic valid;
		logic oldest_nz;
		logic [SAMP_W-1:0] newest;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0] sq_sum;
	} win_t;

endpackage

// ===== rtl/wmvbd_cell.sv =====
// Sample chain cell: holds one sample, takes its neighbor's or a new one on a shift.
module wmvbd_cell import wmvbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input logic [SAMP_W-1:0] shift_in,
	output logic [SAMP_W-1:0] sample
);

	logic [SAMP_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= shift_in;
		end
	end

	assign sample = sample_q;

endmodule

// ===== rtl/wmvbd_eval.sv =====
// Eval pipeline: window spread, band, floor and ceiling compares, output register.
module wmvbd_eval import wmvbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input win_t win,
	input cfg_t cfg,
	output logic out_valid,
	output logic detected
);

	logic v_s2, v_s3, out_valid_q;
	logic [SPREAD_W-1:0] nq_s2, ss_s2, spread_s3;
	logic [LIM_W-1:0] lo_s2, hi_s2, lo_s3, hi_s3;
	logic flags_s2, flags_s3, detected_q;
	logic [2*SUM_W-1:0] sum_sq;
	logic [MEAN_W-1:0] mean_lim;
	logic mean_ok, newest_ok;

	assign sum_sq = win.sum * win.sum;
	assign mean_lim = MEAN_W'(cfg.mean_floor) * MEAN_W'(WINDOW);
	assign mean_ok = MEAN_W'(win.sum) > mean_lim;
	assign newest_ok = win.newest < cfg.newest_ceiling;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s2 <= win.valid;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s2 <= SPREAD_W'(win.sq_sum) * SPREAD_W'(WINDOW);
			ss_s2 <= SPREAD_W'(sum_sq);
			lo_s2 <= LIM_W'(cfg.variance_low) * LIM_W'(WINDOW * WINDOW);
			hi_s2 <= LIM_W'(cfg.variance_high) * LIM_W'(WINDOW * WINDOW);
			flags_s2 <= win.oldest_nz & mean_ok & newest_ok;

			// N*Q >= S*S always, so the spread never wraps.
			spread_s3 <= nq_s2 - ss_s2;
			lo_s3 <= lo_s2;
			hi_s3 <= hi_s2;
			flags_s3 <= flags_s2;

			detected_q <= flags_s3 && (CMP_W'(spread_s3) > CMP_W'(lo_s3))
				&& (CMP_W'(spread_s3) < CMP_W'(hi_s3));
		end
	end

	assign out_valid = out_valid_q;
	assign detected = detected_q;

endmodule

// ===== rtl/window_mean_variance_band_detector.sv =====
// Top level of the window mean/variance band detector: stream ports, registers, sample chain.
// Accepts one brightness item per clock and returns one registered detect flag per item;
// the throughput of one item per cycle is set by the running sum and sum of squares, which
// are updated in the same clock as the shift of the cell chain, and the evaluation pipeline
// behind them (spread, band compares, output register) takes a new item each time it
// advances. The whole pipeline stalls together while a result waits at the output. Samples
// above 100 are stored as 100, the window is all zeros after reset, and the flag stays 0
// until the oldest window entry is a nonzero sample.
`include "window_mean_variance_band_detector_macros.svh"

module window_mean_variance_band_detector import wmvbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [TDATA_W-1:0] s_axis_tdata, // [6:0] brightness
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata, // [0] detected
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	reg_idx_t reg_idx;
	logic en, accept;
	logic [SAMP_W-1:0] x;
	logic [SAMP_W-1:0] samp [WINDOW];
	logic [SAMP_W-1:0] old;
	logic [2*SAMP_W-1:0] old_sq, x_sq;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0] sq_q;
	logic v_s1, oldest_nz_s1;
	logic [SAMP_W-1:0] newest_s1;
	logic detected;
	win_t win;

	// Configuration port.
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_floor <= MEAN_FLOOR_RST;
			cfg_q.variance_low <= VAR_LOW_RST;
			cfg_q.variance_high <= VAR_HIGH_RST;
			cfg_q.newest_ceiling <= CEILING_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_MEAN_FLOOR: cfg_q.mean_floor <= pwdata[FLOOR_CFG_W-1:0];
				REG_VAR_LOW: cfg_q.variance_low <= pwdata[VAR_CFG_W-1:0];
				REG_VAR_HIGH: cfg_q.variance_high <= pwdata[VAR_CFG_W-1:0];
				REG_NEWEST_CEILING: cfg_q.newest_ceiling <= pwdata[FLOOR_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MEAN_FLOOR: prdata = DATA_W'(cfg_q.mean_floor);
			REG_VAR_LOW: prdata = DATA_W'(cfg_q.variance_low);
			REG_VAR_HIGH: prdata = DATA_W'(cfg_q.variance_high);
			REG_NEWEST_CEILING: prdata = DATA_W'(cfg_q.newest_ceiling);
			default: prdata = '0;
		endcase
	end

	// The whole pipeline advances unless a result sits at the output untaken.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign accept = s_axis_tvalid && s_axis_tready;

	assign x = (s_axis_tdata[SAMP_W-1:0] > SAMP_W'(BRIGHT_MAX)) ? SAMP_W'(BRIGHT_MAX)
		: s_axis_tdata[SAMP_W-1:0];

	// Cell 0 holds the oldest sample; a new item enters at the far end.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == WINDOW - 1) begin : g_last
			wmvbd_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(accept), .shift_in(x), .sample(samp[i])
			);
		end else begin : g_mid
			wmvbd_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(accept), .shift_in(samp[i+1]),
				.sample(samp[i])
			);
		end
	end

	assign old = samp[0];
	assign old_sq = old * old;
	assign x_sq = x * x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q <= '0;
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			if (s_axis_tvalid) begin
				sum_q <= sum_q - SUM_W'(old) + SUM_W'(x);
				sq_q <= sq_q - SQ_W'(old_sq) + SQ_W'(x_sq);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			newest_s1 <= x;
			oldest_nz_s1 <= samp[1] != '0;
		end
	end

	assign win.valid = v_s1;
	assign win.oldest_nz = oldest_nz_s1;
	assign win.newest = newest_s1;
	assign win.sum = sum_q;
	assign win.sq_sum = sq_q;

	wmvbd_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.win(win),
		.cfg(cfg_q),
		.out_valid(m_axis_tvalid),
		.detected(detected)
	);

	assign m_axis_tdata = {{(TDATA_W-1){1'b0}}, detected};

	`WMVBD_ASSERT(a_zero_sum_zero_sq, clk, arst_n, (sum_q == '0) |-> (sq_q == '0))
	`WMVBD_ASSERT(a_sq_dominates_sum, clk, arst_n, SQ_W'(sum_q) <= sq_q)
	`WMVBD_ASSERT(a_stall_only_on_held_out, clk, arst_n,
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
	`WMVBD_ASSERT_NEXT(a_newest_clamped, clk, arst_n, accept,
		samp[WINDOW-1] <= SAMP_W'(BRIGHT_MAX))

endmodule

// ===== tb/sv/window_mean_variance_band_detector_test.sv =====
// Self-checking testbench for the window mean/variance band detector.
`timescale 1ns / 100ps

module window_mean_variance_band_detector_test;
	import wmvbd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int STALL_CYCLES = 300;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct packed {
		logic detected;
	} flag_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata; // [6:0] brightness
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata; // [0] detected
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Local copy of the detector's registers and window.
	cfg_t cur_cfg;
	logic [SAMP_W-1:0] win_samples [WINDOW];
	int win_total;
	int win_sq_total;

	logic [SAMP_W-1:0] pending_samples [$];
	flag_item_t expected_flags [$];
	int queued_count = 0;
	int accepted_count = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic item_taken = 1'b0;
	logic stall_on = 1'b0;
	int stall_count = 0;

	window_mean_variance_band_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	task automatic note_mismatch(input string what, input int exp_val, input int act_val);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES) begin
			$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_val,
				act_val);
		end
	endtask

	// Shifts one sample into the window and returns the detect flag that it yields.
	function automatic logic window_hit(input logic [SAMP_W-1:0] raw);
		int x;
		int leaving;
		int spread;
		x = (raw > BRIGHT_MAX) ? BRIGHT_MAX : int'(raw);
		leaving = int'(win_samples[0]);
		for (int i = 0; i < WINDOW - 1; i++)
			win_samples[i] = win_samples[i + 1];
		win_samples[WINDOW - 1] = SAMP_W'(x);
		win_total = win_total - leaving + x;
		win_sq_total = win_sq_total - leaving * leaving + x * x;
		// Mean and variance are compared scaled by N and N*N, so nothing is divided.
		spread = WINDOW * win_sq_total - win_total * win_total;
		return win_samples[0] != '0
			&& win_total > int'(cur_cfg.mean_floor) * WINDOW
			&& spread > int'(cur_cfg.variance_low) * WINDOW * WINDOW
			&& spread < int'(cur_cfg.variance_high) * WINDOW * WINDOW
			&& x < int'(cur_cfg.newest_ceiling);
	endfunction

	// Sender: a new item is offered only once the previous one has been taken.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_flags.push_back('{detected: window_hit(s_axis_tdata[SAMP_W-1:0])});
			accepted_count++;
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!s_axis_tvalid || item_taken) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid = 1'b1;
				s_axis_tdata = TDATA_W'(pending_samples.pop_front());
			end else begin
				s_axis_tvalid = 1'b0;
			end
		end
		item_taken = 1'b0;
	end

	// Receiver and the long hold-off that backs the pipeline up.
	always @(negedge clk) begin
		if (stall_on) begin
			stall_count++;
			if (stall_count >= STALL_CYCLES) begin
				stall_on = 1'b0;
				stall_count = 0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready = !stall_on && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		flag_item_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_flags.size() == 0) begin
				note_mismatch("detected with no item pending", -1, int'(m_axis_tdata[0]));
			end else begin
				want = expected_flags.pop_front();
				if (m_axis_tdata[0] !== want.detected)
					note_mismatch("detected", int'(want.detected), int'(m_axis_tdata[0]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("window_mean_variance_band_detector verification failed");
			$finish;
		end
	end

	task automatic push_sample(input logic [SAMP_W-1:0] sample);
		pending_samples.push_back(sample);
		queued_count++;
	endtask

	task automatic wait_drained();
		while (accepted_count != queued_count || expected_flags.size() != 0)
			@(negedge clk);
	endtask

	// APB write followed by a read-back of the same register.
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] stored;
		stored = (idx == REG_MEAN_FLOOR || idx == REG_NEWEST_CEILING) ?
			(value & 32'h7F) : (value & 32'hFFF);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MEAN_FLOOR: cur_cfg.mean_floor = stored[FLOOR_CFG_W-1:0];
			REG_VAR_LOW: cur_cfg.variance_low = stored[VAR_CFG_W-1:0];
			REG_VAR_HIGH: cur_cfg.variance_high = stored[VAR_CFG_W-1:0];
			default: cur_cfg.newest_ceiling = stored[FLOOR_CFG_W-1:0];
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored)
			note_mismatch("register read-back", stored, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_thresholds(input int floor_val, input int low_val, input int high_val,
			input int ceil_val);
		write_reg(REG_MEAN_FLOOR, DATA_W'(floor_val));
		write_reg(REG_VAR_LOW, DATA_W'(low_val));
		write_reg(REG_VAR_HIGH, DATA_W'(high_val));
		write_reg(REG_NEWEST_CEILING, DATA_W'(ceil_val));
	endtask

	// Mostly runs of samples around a level with a chosen scatter, so that the mean and
	// variance land near the band; the rest is noise, zeros and samples above full scale.
	task automatic queue_random(input int count);
		int level;
		int scatter;
		int pick;
		int val;
		level = 50;
		scatter = 20;
		for (int i = 0; i < count; i++) begin
			if (i % 12 == 0) begin
				level = $urandom_range(90, 10);
				scatter = $urandom_range(50);
			end
			pick = $urandom_range(99);
			if (pick < 80) begin
				val = level + $urandom_range(2 * scatter) - scatter;
				val = (val < 0) ? 0 : (val > BRIGHT_MAX) ? BRIGHT_MAX : val;
			end else if (pick < 90) begin
				val = $urandom_range(127);
			end else if (pick < 95) begin
				val = 0;
			end else begin
				val = $urandom_range(127, BRIGHT_MAX + 1);
			end
			push_sample(SAMP_W'(val));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_cfg = '{mean_floor: MEAN_FLOOR_RST, variance_low: VAR_LOW_RST,
			variance_high: VAR_HIGH_RST, newest_ceiling: CEILING_RST};
		for (int i = 0; i < WINDOW; i++)
			win_samples[i] = '0;
		win_total = 0;
		win_sq_total = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 37;
		recv_idle_pct = 64;
		// Directed: partly filled window, clamping, single bits, then a gray pattern
		// (mean 60, variance 400) that hits only when the newest sample is the dark one.
		push_sample(7'd0);
		push_sample(7'd127);
		push_sample(7'd101);
		push_sample(7'd100);
		for (int b = 6; b >= 0; b--)
			push_sample(SAMP_W'(1 << b));
		for (int i = 0; i < 12; i++)
			push_sample((i % 2 == 0) ? 7'd80 : 7'd40);
		wait_drained();

		// Widest band with junk above the register widths.
		set_thresholds(0, 32'hFFFF_F000, 32'hFFFF_FFFF, 127);
		queue_random(250);
		wait_drained();

		send_idle_pct = 64;
		recv_idle_pct = 37;
		// Nothing can pass: inverted band and zero ceiling.
		set_thresholds(127, 4095, 0, 0);
		queue_random(150);
		wait_drained();

		set_thresholds($urandom_range(100), $urandom_range(600), $urandom_range(2500, 600),
			$urandom_range(100));
		queue_random(250);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Empty band with equal edges.
		set_thresholds(30, 400, 400, 90);
		queue_random(100);
		wait_drained();

		set_thresholds(MEAN_FLOOR_RST, VAR_LOW_RST, VAR_HIGH_RST, CEILING_RST);
		stall_on = 1'b1;
		queue_random(250);
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("window_mean_variance_band_detector verification clean");
		else
			$display("window_mean_variance_band_detector verification failed");
		$finish;
	end

endmodule

// ===== window_mean_variance_band_detector.f =====
+incdir+rtl
rtl/wmvbd_pkg.sv
rtl/wmvbd_cell.sv
rtl/wmvbd_eval.sv
rtl/window_mean_variance_band_detector.sv
tb/sv/window_mean_variance_band_detector_test.sv
